// ===== design/crr_pkg.sv =====
// crr_pkg: shared constants for the chained range remap block
// field widths, command codes and parameter defaults
// no dependencies
`timescale 1ns / 1ps

package crr_pkg;

    // fixed field widths of the command and result words
    localparam int MODE_W  = 2;
    localparam int STAGE_W = 3;
    localparam int SLOT_W  = 5;
    localparam int FIELD_W = 32;

    // parameter defaults
    localparam int STAGES_DEF            = 7;
    localparam int ENTRIES_PER_STAGE_DEF = 32;
    localparam int VALUE_BITS_DEF        = 32;

    // command codes
    localparam logic [MODE_W-1:0] MODE_LOAD      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRANSLATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR     = 2'd2;

endpackage

// ===== design/crr_entry_mem.sv =====
// crr_entry_mem: range entry memory with per-entry valid flags
// one write port, one registered read port
// depends on crr_pkg
`timescale 1ns / 1ps

module crr_entry_mem
    import crr_pkg::*;
#(
    parameter int TOTAL      = STAGES_DEF * ENTRIES_PER_STAGE_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int ADDR_W     = (TOTAL > 1) ? $clog2(TOTAL) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic                  i_wr_en,
    input  logic [ADDR_W-1:0]     i_wr_addr,
    input  logic [VALUE_BITS-1:0] i_wr_src,
    input  logic [VALUE_BITS-1:0] i_wr_dest,
    input  logic [FIELD_W-1:0]    i_wr_span,
    input  logic                  i_rd_en,
    input  logic [ADDR_W-1:0]     i_rd_addr,
    output logic                  o_rd_valid,
    output logic [VALUE_BITS-1:0] o_rd_src,
    output logic [VALUE_BITS-1:0] o_rd_dest,
    output logic [FIELD_W-1:0]    o_rd_span
);

    localparam int WORD_W = FIELD_W + 2 * VALUE_BITS;

    logic [WORD_W-1:0] r_mem [TOTAL];
    logic [TOTAL-1:0]  r_valid;
    logic [WORD_W-1:0] r_rd_word;
    logic              r_rd_valid;

    // entry words: no reset, only read behind a set valid flag
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_span, i_wr_dest, i_wr_src};
        end
        if (i_rd_en) begin
            r_rd_word <= r_mem[i_rd_addr];
        end
    end

    // valid flags: cleared at once by reset or clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= (i_wr_span != '0);
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_src   = r_rd_word[VALUE_BITS-1:0];
    assign o_rd_dest  = r_rd_word[2*VALUE_BITS-1:VALUE_BITS];
    assign o_rd_span  = r_rd_word[WORD_W-1:2*VALUE_BITS];

endmodule

// ===== design/crr_scan.sv =====
// crr_scan: translate sequencer, streams every entry through the match logic
// keeps the running minimum and drives the result word
// depends on crr_pkg
`timescale 1ns / 1ps

module crr_scan
    import crr_pkg::*;
#(
    parameter int STAGES            = STAGES_DEF,
    parameter int ENTRIES_PER_STAGE = ENTRIES_PER_STAGE_DEF,
    parameter int VALUE_BITS        = VALUE_BITS_DEF,
    parameter int ADDR_W            = (STAGES * ENTRIES_PER_STAGE > 1)
                                      ? $clog2(STAGES * ENTRIES_PER_STAGE) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  logic                  i_clear,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_busy,
    output logic                  o_rd_en,
    output logic [ADDR_W-1:0]     o_rd_addr,
    input  logic                  i_rd_valid,
    input  logic [VALUE_BITS-1:0] i_rd_src,
    input  logic [VALUE_BITS-1:0] i_rd_dest,
    input  logic [FIELD_W-1:0]    i_rd_span,
    output logic                  o_valid,
    output logic [FIELD_W-1:0]    o_location,
    output logic [FIELD_W-1:0]    o_lowest_location
);

    localparam int SLOT_CW = (ENTRIES_PER_STAGE > 1) ? $clog2(ENTRIES_PER_STAGE) : 1;
    localparam int STG_CW  = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int CMP_W   = (VALUE_BITS > FIELD_W) ? VALUE_BITS : FIELD_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state                r_state;
    logic [ADDR_W-1:0]     r_addr;
    logic [SLOT_CW-1:0]    r_slot;
    logic [STG_CW-1:0]     r_stg;
    logic                  r_ev;
    logic                  r_ev_eos;
    logic                  r_ev_end;
    logic                  r_hit;
    logic [VALUE_BITS-1:0] r_next;
    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] r_min;
    logic                  r_valid;
    logic [FIELD_W-1:0]    r_location;
    logic [FIELD_W-1:0]    r_lowest;

    logic                  iss_eos;
    logic                  iss_end;
    logic [VALUE_BITS-1:0] diff;
    logic                  hit;
    logic [VALUE_BITS-1:0] mapped;
    logic [VALUE_BITS-1:0] n_value;
    logic [VALUE_BITS-1:0] n_min;

    // position of the entry issued this cycle
    assign iss_eos = (r_slot == SLOT_CW'(ENTRIES_PER_STAGE - 1));
    assign iss_end = iss_eos && (r_stg == STG_CW'(STAGES - 1));

    // match of the entry read last cycle against the current stage input
    assign diff   = r_value - i_rd_src;
    assign hit    = i_rd_valid && (r_value >= i_rd_src)
                    && (CMP_W'(diff) < CMP_W'(i_rd_span));
    assign mapped = diff + i_rd_dest;

    // stage output: first hit of the stage, else unchanged
    always_comb begin
        priority if (r_hit) begin
            n_value = r_next;
        end else if (hit) begin
            n_value = mapped;
        end else begin
            n_value = r_value;
        end
    end

    assign n_min = (r_value < r_min) ? r_value : r_min;

    // sequencer, match pipeline and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ev    <= 1'b0;
            r_hit   <= 1'b0;
            r_valid <= 1'b0;
            r_min   <= '1;
        end else begin
            r_valid <= (r_state == S_FINISH);
            if (i_clear) begin
                r_min <= '1;
            end

            // evaluate the entry that came out of memory
            if (r_ev) begin
                if (r_ev_eos) begin
                    r_value <= n_value;
                    r_hit   <= 1'b0;
                end else if (!r_hit && hit) begin
                    r_hit  <= 1'b1;
                    r_next <= mapped;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    r_ev <= 1'b0;
                    if (i_go) begin
                        r_value <= i_value;
                        r_addr  <= '0;
                        r_slot  <= '0;
                        r_stg   <= '0;
                        r_hit   <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_ev     <= 1'b1;
                    r_ev_eos <= iss_eos;
                    r_ev_end <= iss_end;
                    r_addr   <= r_addr + ADDR_W'(1);
                    if (iss_eos) begin
                        r_slot <= '0;
                        r_stg  <= r_stg + STG_CW'(1);
                    end else begin
                        r_slot <= r_slot + SLOT_CW'(1);
                    end
                    if (iss_end) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_ev <= 1'b0;
                    if (r_ev && r_ev_end) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    r_min      <= n_min;
                    r_location <= FIELD_W'(r_value);
                    r_lowest   <= FIELD_W'(n_min);
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy            = (r_state != S_IDLE);
    assign o_rd_en           = (r_state == S_SCAN);
    assign o_rd_addr         = r_addr;
    assign o_valid           = r_valid;
    assign o_location        = r_location;
    assign o_lowest_location = r_lowest;

endmodule

// ===== design/chained_range_remap.sv =====
// chained_range_remap: top level, command decode around entry memory and scanner
// depends on crr_pkg, crr_entry_mem, crr_scan
// Usage: a command word is taken when start is high and busy is low. Load
// and clear take effect in that one cycle and busy stays low, so commands of
// that kind can follow every cycle. A translate reads every entry of every
// stage from the single read port of the entry memory, one entry per cycle, so
// busy stays high through the scan, a drain state and a finish state, and the
// result word shows on o_location and o_lowest_location with o_valid high for
// exactly one cycle, starting in the cycle busy goes low; a new command may be
// taken in that same cycle. There is no stall on the result side: the receiver
// must take the word in the cycle o_valid is high.
`timescale 1ns / 1ps

module chained_range_remap
    import crr_pkg::*;
#(
    parameter int STAGES            = STAGES_DEF,
    parameter int ENTRIES_PER_STAGE = ENTRIES_PER_STAGE_DEF,
    parameter int VALUE_BITS        = VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [STAGE_W-1:0] i_stage,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [FIELD_W-1:0] i_dest_start,
    input  logic [FIELD_W-1:0] i_source_start,
    input  logic [FIELD_W-1:0] i_span_length,
    input  logic [FIELD_W-1:0] i_value,
    output logic               o_valid,
    output logic [FIELD_W-1:0] o_location,
    output logic [FIELD_W-1:0] o_lowest_location
);

    localparam int TOTAL  = STAGES * ENTRIES_PER_STAGE;
    localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;

    logic                  accept;
    logic                  load_ok;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic                  clear;
    logic                  go;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  rd_valid;
    logic [VALUE_BITS-1:0] rd_src;
    logic [VALUE_BITS-1:0] rd_dest;
    logic [FIELD_W-1:0]    rd_span;

    // command decode
    assign accept  = start && !busy;
    assign load_ok = (32'(i_stage) < STAGES) && (32'(i_slot) < ENTRIES_PER_STAGE);
    assign wr_en   = accept && (i_mode == MODE_LOAD) && load_ok;
    assign wr_addr = ADDR_W'(32'(i_stage) * ENTRIES_PER_STAGE + 32'(i_slot));
    assign clear   = accept && (i_mode == MODE_CLEAR);
    assign go      = accept && (i_mode == MODE_TRANSLATE);

    crr_entry_mem #(
        .TOTAL      (TOTAL),
        .VALUE_BITS (VALUE_BITS),
        .ADDR_W     (ADDR_W)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (clear),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_src   (VALUE_BITS'(i_source_start)),
        .i_wr_dest  (VALUE_BITS'(i_dest_start)),
        .i_wr_span  (i_span_length),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_valid (rd_valid),
        .o_rd_src   (rd_src),
        .o_rd_dest  (rd_dest),
        .o_rd_span  (rd_span)
    );

    crr_scan #(
        .STAGES            (STAGES),
        .ENTRIES_PER_STAGE (ENTRIES_PER_STAGE),
        .VALUE_BITS        (VALUE_BITS),
        .ADDR_W            (ADDR_W)
    ) u_scan (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_go              (go),
        .i_clear           (clear),
        .i_value           (VALUE_BITS'(i_value)),
        .o_busy            (busy),
        .o_rd_en           (rd_en),
        .o_rd_addr         (rd_addr),
        .i_rd_valid        (rd_valid),
        .i_rd_src          (rd_src),
        .i_rd_dest         (rd_dest),
        .i_rd_span         (rd_span),
        .o_valid           (o_valid),
        .o_location        (o_location),
        .o_lowest_location (o_lowest_location)
    );

endmodule
